// ===== rtl/core/rnvs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Resistor network solver package
// Shared widths, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package rnvs_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    localparam int CMD_W     = 3;
    localparam int ID_W      = 6;
    localparam int RES_W     = 24;
    localparam int VOLT_W    = 32;
    localparam int CFG_W     = 16;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int G_W       = 37;
    localparam int G_SHIFT   = 36;
    localparam int WORST_W   = VOLT_W + 1;

    localparam logic [CFG_W-1:0] TOL_RESET    = 16'd7;
    localparam logic [CFG_W-1:0] SWEEPS_RESET = 16'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_FIX   = 3'd2,
        CMD_UNFIX = 3'd3,
        CMD_SOLVE = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_SELF   = 3'd2,
        ST_LIMIT  = 3'd3,
        ST_NONODE = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOLERANCE  = 1'b0,
        REG_MAX_SWEEPS = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RESP,
        S_GDIV,
        S_NODE,
        S_SELF_CAP,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_DIV_START,
        S_VDIV,
        S_NODE_ADV,
        S_SWEEP_END,
        S_OUT_SCAN,
        S_OUT_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    clear;
        logic    add_write;
        logic    fix_write;
        logic    unfix;
        logic    set_rsp;
        status_t rsp_code;
        logic    div_g;
        logic    div_v;
        logic    sweep_start;
        logic    sweeps_clear;
        logic    node_begin;
        logic    node_next;
        logic    vrd_self;
        logic    vrd_other;
        logic    edge_rd;
        logic    edge_skip;
        logic    mul_lo;
        logic    mul_hi;
        logic    acc_add;
        logic    node_update;
        logic    set_final;
        logic    emit_single;
        logic    emit_node;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             self_loop;
        logic             a_in_range;
        logic             ab_in_range;
        logic             table_full;
        logic             any_present;
        logic             node_active;
        logic             node_present;
        logic             node_last;
        logic             edge_more;
        logic             edge_match;
        logic             den_zero;
        logic             div_done;
        logic             need_sweep;
        logic             out_free;
        logic             out_last;
    } dp_stat_t;

endpackage

// ===== rtl/core/rnvs_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one command word.
// ---------------------------------------------------------------------------
interface rnvs_in_if;
    logic                             valid;
    logic                             ready;
    logic [rnvs_pkg::CMD_W-1:0]       command;
    logic [rnvs_pkg::ID_W-1:0]        node_a;
    logic [rnvs_pkg::ID_W-1:0]        node_b;
    logic [rnvs_pkg::RES_W-1:0]       resistance;
    logic signed [rnvs_pkg::VOLT_W-1:0] voltage;

    modport source (output valid, command, node_a, node_b, resistance, voltage,
                    input ready);
    modport sink   (input valid, command, node_a, node_b, resistance, voltage,
                    output ready);
endinterface

// ===== rtl/core/rnvs_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one result word.
// ---------------------------------------------------------------------------
interface rnvs_out_if;
    logic                               valid;
    logic                               ready;
    logic [rnvs_pkg::STAT_W-1:0]        status;
    logic [rnvs_pkg::ID_W-1:0]          node_id;
    logic signed [rnvs_pkg::VOLT_W-1:0] node_voltage;
    logic [rnvs_pkg::CFG_W-1:0]         sweeps_used;
    logic                               last;

    modport source (output valid, status, node_id, node_voltage, sweeps_used, last,
                    input ready);
    modport sink   (input valid, status, node_id, node_voltage, sweeps_used, last,
                    output ready);
endinterface

// ===== rtl/core/resistor_network_voltage_solver_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Resistor network voltage solver
// Gauss-Seidel nodal relaxation over a loaded resistor network.
// ---------------------------------------------------------------------------
// Words are taken one at a time and each gives its results before the next
// is accepted. Clear, fix, unfix and rejected adds go straight to their
// result word, which waits for the output. An accepted add computes its
// conductance in the shared serial divider, one quotient bit per cycle.
// A solve's time is bound by the single edge-table read port and that
// divider: per sweep, each present, unfixed node reads every stored edge,
// multiplies and accumulates each one that touches it, and divides when its
// total conductance is not zero; every other node id is skipped. After the
// last sweep each present node gives one result word and each absent node
// id is skipped.
module resistor_network_voltage_solver_top #(
    parameter int MAX_NODES = rnvs_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = rnvs_pkg::DEF_MAX_EDGES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rnvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rnvs_pkg::CFG_W-1:0]     cfg_data,
    rnvs_in_if.sink                        in_ch,
    rnvs_out_if.source                     out_ch
);

    rnvs_pkg::ctrl_cmd_t cmd;
    rnvs_pkg::dp_stat_t  stat;

    // Sequencer.
    rnvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Storage and arithmetic.
    rnvs_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (in_ch.command),
        .node_a       (in_ch.node_a),
        .node_b       (in_ch.node_b),
        .resistance   (in_ch.resistance),
        .voltage      (in_ch.voltage),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .status       (out_ch.status),
        .node_id      (out_ch.node_id),
        .node_voltage (out_ch.node_voltage),
        .sweeps_used  (out_ch.sweeps_used),
        .last         (out_ch.last),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== rtl/core/rnvs_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rnvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; data holds between reads.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rnvs_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rnvs_div #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 32,
    parameter int Q_W   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [DVS_W:0]   rem_shift;
    logic             fits;
    logic             last_step;

    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign last_step = cnt_reg == CNT_W'(DVD_W - 1);

    // Control: step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: shift in one dividend bit and try a subtract.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[Q_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DVS_W'(rem_shift - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= rem_shift[DVS_W-1:0];
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/rnvs_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Solver datapath
// Edge and voltage memories, node marks, accumulators, the shared divider
// and the output register.
// ---------------------------------------------------------------------------
module rnvs_datapath #(
    parameter int MAX_NODES = rnvs_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = rnvs_pkg::DEF_MAX_EDGES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rnvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rnvs_pkg::CFG_W-1:0]         cfg_data,
    input  logic [rnvs_pkg::CMD_W-1:0]         command,
    input  logic [rnvs_pkg::ID_W-1:0]          node_a,
    input  logic [rnvs_pkg::ID_W-1:0]          node_b,
    input  logic [rnvs_pkg::RES_W-1:0]         resistance,
    input  logic signed [rnvs_pkg::VOLT_W-1:0] voltage,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [rnvs_pkg::STAT_W-1:0]        status,
    output logic [rnvs_pkg::ID_W-1:0]          node_id,
    output logic signed [rnvs_pkg::VOLT_W-1:0] node_voltage,
    output logic [rnvs_pkg::CFG_W-1:0]         sweeps_used,
    output logic                               last,
    input  rnvs_pkg::ctrl_cmd_t                cmd,
    output rnvs_pkg::dp_stat_t                 stat
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int EA_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W    = $clog2(MAX_EDGES + 1);
    localparam int G_W     = rnvs_pkg::G_W;
    localparam int V_W     = rnvs_pkg::VOLT_W;
    localparam int DEN_W   = G_W + EC_W;
    localparam int ACC_W   = G_W + V_W + EC_W + 1;
    localparam int EDGE_W  = 2 * NODE_W + G_W;
    localparam int PROD_W  = V_W + V_W + 1;
    localparam int WORST_W = rnvs_pkg::WORST_W;
    localparam logic [ACC_W-1:0] G_NUM = ACC_W'(1) << rnvs_pkg::G_SHIFT;

    // Latched input word.
    logic [rnvs_pkg::CMD_W-1:0] cmd_reg;
    logic [rnvs_pkg::ID_W-1:0]  a_reg;
    logic [rnvs_pkg::ID_W-1:0]  b_reg;
    logic [rnvs_pkg::RES_W-1:0] r_reg;
    logic signed [V_W-1:0]      v_reg;

    // Configuration.
    logic [rnvs_pkg::CFG_W-1:0] tol_reg;
    logic [rnvs_pkg::CFG_W-1:0] maxsw_reg;

    // Network state.
    logic [EC_W-1:0]      edge_count_reg;
    logic [MAX_NODES-1:0] present_reg;
    logic [MAX_NODES-1:0] fixed_reg;
    logic [MAX_NODES-1:0] vvalid_reg;

    // Solve state.
    logic [NODE_W-1:0]          node_reg;
    logic [EC_W-1:0]            eidx_reg;
    logic [rnvs_pkg::CFG_W-1:0] sweeps_reg;
    logic [WORST_W-1:0]         worst_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    prod_reg;
    logic [DEN_W-1:0]           den_reg;
    logic signed [V_W-1:0]      old_v_reg;
    logic                       vq_valid_reg;
    rnvs_pkg::status_t          rsp_reg;

    // Output register.
    logic                        out_valid_reg;
    logic [rnvs_pkg::STAT_W-1:0] out_status_reg;
    logic [rnvs_pkg::ID_W-1:0]   out_id_reg;
    logic signed [V_W-1:0]       out_volt_reg;
    logic [rnvs_pkg::CFG_W-1:0]  out_sweeps_reg;
    logic                        out_last_reg;

    logic [NODE_W-1:0] a_idx;
    logic [NODE_W-1:0] b_idx;
    logic [EDGE_W-1:0] edge_q;
    logic [NODE_W-1:0] e_a;
    logic [NODE_W-1:0] e_b;
    logic [G_W-1:0]    e_g;
    logic [NODE_W-1:0] other;
    logic [V_W-1:0]    vram_q;
    logic signed [V_W-1:0] vq_val;
    logic              v_we;
    logic [NODE_W-1:0] v_waddr;
    logic [V_W-1:0]    v_wdata;
    logic              v_re;
    logic [NODE_W-1:0] v_raddr;
    logic [V_W-1:0]    m_a;
    logic signed [PROD_W-1:0] m_prod;
    logic signed [ACC_W-1:0]  m_ext;
    logic [ACC_W-1:0]  acc_mag;
    logic              div_start;
    logic [ACC_W-1:0]  div_dvd;
    logic [DEN_W-1:0]  div_dvs;
    logic [G_W-1:0]    div_q;
    logic              div_done;
    logic [rnvs_pkg::RES_W-1:0] r_eff;
    logic signed [V_W-1:0]  nv;
    logic signed [V_W:0]    diff;
    logic [WORST_W-1:0]     change;
    logic [rnvs_pkg::CFG_W-1:0] limit;
    logic                   over_tol;
    logic                   higher_present;

    assign a_idx = a_reg[NODE_W-1:0];
    assign b_idx = b_reg[NODE_W-1:0];

    // Edge table: both node ids and the conductance in one word.
    assign r_eff = (r_reg == '0) ? rnvs_pkg::RES_W'(1) : r_reg;

    rnvs_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (cmd.add_write),
        .waddr (edge_count_reg[EA_W-1:0]),
        .wdata ({a_idx, b_idx, div_q}),
        .re    (cmd.edge_rd),
        .raddr (eidx_reg[EA_W-1:0]),
        .rdata (edge_q)
    );

    assign e_a   = edge_q[EDGE_W-1 -: NODE_W];
    assign e_b   = edge_q[G_W +: NODE_W];
    assign e_g   = edge_q[G_W-1:0];
    assign other = (e_a == node_reg) ? e_b : e_a;

    // Node voltages; an entry not written since clear reads as zero.
    assign v_we    = cmd.fix_write || cmd.node_update;
    assign v_waddr = cmd.fix_write ? a_idx : node_reg;
    assign v_wdata = cmd.fix_write ? v_reg : nv;
    assign v_re    = cmd.vrd_self || cmd.vrd_other;
    assign v_raddr = cmd.vrd_other ? other : node_reg;

    rnvs_ram #(
        .WIDTH (V_W),
        .DEPTH (MAX_NODES)
    ) u_volt_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (vram_q)
    );

    assign vq_val = vq_valid_reg ? $signed(vram_q) : '0;

    // One multiplier for both halves of the 37-bit conductance.
    assign m_a    = cmd.mul_hi ? V_W'(e_g[G_W-1:V_W]) : e_g[V_W-1:0];
    assign m_prod = $signed({1'b0, m_a}) * vq_val;
    assign m_ext  = ACC_W'(m_prod);

    // Shared divider: conductance on add, weighted mean on solve.
    assign acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign div_start = cmd.div_g || cmd.div_v;
    assign div_dvd   = cmd.div_g ? G_NUM : acc_mag;
    assign div_dvs   = cmd.div_g ? DEN_W'(r_eff) : den_reg;

    rnvs_div #(
        .DVD_W (ACC_W),
        .DVS_W (DEN_W),
        .Q_W   (G_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    // Signed, saturated new voltage and its change.
    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            nv = (div_q >= G_W'(33'h080000000)) ? $signed(32'h80000000)
                                                 : $signed(-div_q[V_W-1:0]);
        end
        else
        begin
            nv = (div_q >= G_W'(32'h7FFFFFFF)) ? $signed(32'h7FFFFFFF)
                                                : $signed(div_q[V_W-1:0]);
        end
        diff   = {nv[V_W-1], nv} - {old_v_reg[V_W-1], old_v_reg};
        change = diff[V_W] ? WORST_W'(-diff) : WORST_W'(diff);
    end

    // Convergence test and the last-result flag.
    assign limit    = (maxsw_reg == '0) ? rnvs_pkg::CFG_W'(1) : maxsw_reg;
    assign over_tol = worst_reg > WORST_W'(tol_reg);

    always_comb
    begin
        higher_present = 1'b0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (present_reg[i] && (NODE_W'(i) > node_reg))
            begin
                higher_present = 1'b1;
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.self_loop    = a_reg == b_reg;
        stat.a_in_range   = int'(a_reg) < MAX_NODES;
        stat.ab_in_range  = (int'(a_reg) < MAX_NODES) && (int'(b_reg) < MAX_NODES);
        stat.table_full   = edge_count_reg == EC_W'(MAX_EDGES);
        stat.any_present  = |present_reg;
        stat.node_active  = present_reg[node_reg] && !fixed_reg[node_reg];
        stat.node_present = present_reg[node_reg];
        stat.node_last    = node_reg == NODE_W'(MAX_NODES - 1);
        stat.edge_more    = eidx_reg < edge_count_reg;
        stat.edge_match   = (e_a == node_reg) || (e_b == node_reg);
        stat.den_zero     = den_reg == '0;
        stat.div_done     = div_done;
        stat.need_sweep   = over_tol && (sweeps_reg < limit);
        stat.out_free     = !out_valid_reg || out_ready;
        stat.out_last     = !higher_present;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= rnvs_pkg::TOL_RESET;
            maxsw_reg <= rnvs_pkg::SWEEPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rnvs_pkg::REG_TOLERANCE:  tol_reg   <= cfg_data;
                rnvs_pkg::REG_MAX_SWEEPS: maxsw_reg <= cfg_data;
                default:                  tol_reg   <= tol_reg;
            endcase
        end
    end

    // Network marks, counters and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            present_reg    <= '0;
            fixed_reg      <= '0;
            vvalid_reg     <= '0;
            node_reg       <= '0;
            eidx_reg       <= '0;
            sweeps_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                edge_count_reg <= '0;
                present_reg    <= '0;
                fixed_reg      <= '0;
                vvalid_reg     <= '0;
            end
            if (cmd.add_write)
            begin
                edge_count_reg     <= edge_count_reg + 1'b1;
                present_reg[a_idx] <= 1'b1;
                present_reg[b_idx] <= 1'b1;
            end
            if (cmd.fix_write)
            begin
                present_reg[a_idx] <= 1'b1;
                fixed_reg[a_idx]   <= 1'b1;
            end
            if (cmd.unfix)
            begin
                fixed_reg[a_idx] <= 1'b0;
            end
            if (v_we)
            begin
                vvalid_reg[v_waddr] <= 1'b1;
            end

            // Node walk.
            if (cmd.sweep_start || cmd.set_final)
            begin
                node_reg <= '0;
            end
            else if (cmd.node_next)
            begin
                node_reg <= node_reg + 1'b1;
            end

            // Edge walk.
            if (cmd.node_begin)
            begin
                eidx_reg <= '0;
            end
            else if (cmd.edge_skip || cmd.acc_add)
            begin
                eidx_reg <= eidx_reg + 1'b1;
            end

            // Sweep count.
            if (cmd.sweep_start)
            begin
                sweeps_reg <= cmd.sweeps_clear ? rnvs_pkg::CFG_W'(1)
                                               : sweeps_reg + 1'b1;
            end

            // Output handshake.
            if (cmd.emit_single || cmd.emit_node)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            a_reg   <= node_a;
            b_reg   <= node_b;
            r_reg   <= resistance;
            v_reg   <= voltage;
        end
        if (cmd.set_rsp)
        begin
            rsp_reg <= cmd.rsp_code;
        end
        else if (cmd.set_final)
        begin
            rsp_reg <= over_tol ? rnvs_pkg::ST_LIMIT : rnvs_pkg::ST_OK;
        end
        if (v_re)
        begin
            vq_valid_reg <= vvalid_reg[v_raddr];
        end

        // Per-node accumulation.
        if (cmd.node_begin)
        begin
            acc_reg   <= '0;
            den_reg   <= '0;
            old_v_reg <= vq_val;
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= m_ext;
            den_reg  <= den_reg + DEN_W'(e_g);
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= m_ext <<< V_W;
            acc_reg  <= acc_reg + prod_reg;
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end

        // Largest change in the current sweep.
        if (cmd.sweep_start)
        begin
            worst_reg <= '0;
        end
        else if (cmd.node_update && (change > worst_reg))
        begin
            worst_reg <= change;
        end

        // Result word.
        if (cmd.emit_single)
        begin
            out_status_reg <= rsp_reg;
            out_id_reg     <= '0;
            out_volt_reg   <= '0;
            out_sweeps_reg <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_node)
        begin
            out_status_reg <= rsp_reg;
            out_id_reg     <= rnvs_pkg::ID_W'(node_reg);
            out_volt_reg   <= vq_val;
            out_sweeps_reg <= sweeps_reg;
            out_last_reg   <= !higher_present;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign node_id      = out_id_reg;
    assign node_voltage = out_volt_reg;
    assign sweeps_used  = out_sweeps_reg;
    assign last         = out_last_reg;

endmodule

// ===== rtl/core/rnvs_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Solver controller
// State machine that sequences commands, sweeps, edge scans and results.
// ---------------------------------------------------------------------------
module rnvs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output rnvs_pkg::ctrl_cmd_t cmd,
    input  rnvs_pkg::dp_stat_t  stat
);

    rnvs_pkg::state_t state_reg;
    rnvs_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rnvs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rnvs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rnvs_pkg::S_DECODE;
                end
            end
            rnvs_pkg::S_DECODE:
            begin
                state_next = rnvs_pkg::S_RESP;
                case (stat.cmd)
                    rnvs_pkg::CMD_ADD:
                    begin
                        if (!stat.self_loop && stat.ab_in_range && !stat.table_full)
                        begin
                            state_next = rnvs_pkg::S_GDIV;
                        end
                    end
                    rnvs_pkg::CMD_SOLVE:
                    begin
                        if (stat.any_present)
                        begin
                            state_next = rnvs_pkg::S_NODE;
                        end
                    end
                    default: state_next = rnvs_pkg::S_RESP;
                endcase
            end
            rnvs_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = rnvs_pkg::S_IDLE;
                end
            end
            rnvs_pkg::S_GDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = rnvs_pkg::S_RESP;
                end
            end
            rnvs_pkg::S_NODE:
            begin
                if (stat.node_active)
                begin
                    state_next = rnvs_pkg::S_SELF_CAP;
                end
                else if (stat.node_last)
                begin
                    state_next = rnvs_pkg::S_SWEEP_END;
                end
            end
            rnvs_pkg::S_SELF_CAP: state_next = rnvs_pkg::S_EDGE_RD;
            rnvs_pkg::S_EDGE_RD:
            begin
                state_next = stat.edge_more ? rnvs_pkg::S_EDGE_CHK
                                            : rnvs_pkg::S_DIV_START;
            end
            rnvs_pkg::S_EDGE_CHK:
            begin
                state_next = stat.edge_match ? rnvs_pkg::S_MUL_LO
                                             : rnvs_pkg::S_EDGE_RD;
            end
            rnvs_pkg::S_MUL_LO: state_next = rnvs_pkg::S_MUL_HI;
            rnvs_pkg::S_MUL_HI: state_next = rnvs_pkg::S_ACC;
            rnvs_pkg::S_ACC:    state_next = rnvs_pkg::S_EDGE_RD;
            rnvs_pkg::S_DIV_START:
            begin
                state_next = stat.den_zero ? rnvs_pkg::S_NODE_ADV : rnvs_pkg::S_VDIV;
            end
            rnvs_pkg::S_VDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = rnvs_pkg::S_NODE_ADV;
                end
            end
            rnvs_pkg::S_NODE_ADV:
            begin
                state_next = stat.node_last ? rnvs_pkg::S_SWEEP_END : rnvs_pkg::S_NODE;
            end
            rnvs_pkg::S_SWEEP_END:
            begin
                state_next = stat.need_sweep ? rnvs_pkg::S_NODE : rnvs_pkg::S_OUT_SCAN;
            end
            rnvs_pkg::S_OUT_SCAN:
            begin
                if (stat.node_present)
                begin
                    state_next = rnvs_pkg::S_OUT_EMIT;
                end
            end
            rnvs_pkg::S_OUT_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.out_last ? rnvs_pkg::S_IDLE : rnvs_pkg::S_OUT_SCAN;
                end
            end
            default: state_next = rnvs_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd          = '0;
        cmd.rsp_code = rnvs_pkg::ST_OK;
        in_ready     = state_reg == rnvs_pkg::S_IDLE;
        case (state_reg)
            rnvs_pkg::S_IDLE:
            begin
                cmd.load = in_valid;
            end
            rnvs_pkg::S_DECODE:
            begin
                cmd.set_rsp = 1'b1;
                case (stat.cmd)
                    rnvs_pkg::CMD_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    rnvs_pkg::CMD_ADD:
                    begin
                        if (stat.self_loop)
                        begin
                            cmd.rsp_code = rnvs_pkg::ST_SELF;
                        end
                        else if (stat.ab_in_range && stat.table_full)
                        begin
                            cmd.rsp_code = rnvs_pkg::ST_FULL;
                        end
                        else if (stat.ab_in_range)
                        begin
                            cmd.div_g = 1'b1;
                        end
                    end
                    rnvs_pkg::CMD_FIX:
                    begin
                        cmd.fix_write = stat.a_in_range;
                    end
                    rnvs_pkg::CMD_UNFIX:
                    begin
                        cmd.unfix = stat.a_in_range;
                    end
                    rnvs_pkg::CMD_SOLVE:
                    begin
                        if (stat.any_present)
                        begin
                            cmd.set_rsp      = 1'b0;
                            cmd.sweep_start  = 1'b1;
                            cmd.sweeps_clear = 1'b1;
                        end
                        else
                        begin
                            cmd.rsp_code = rnvs_pkg::ST_NONODE;
                        end
                    end
                    default: cmd.set_rsp = 1'b1;
                endcase
            end
            rnvs_pkg::S_RESP:
            begin
                cmd.emit_single = stat.out_free;
            end
            rnvs_pkg::S_GDIV:
            begin
                cmd.add_write = stat.div_done;
            end
            rnvs_pkg::S_NODE:
            begin
                cmd.vrd_self  = stat.node_active;
                cmd.node_next = !stat.node_active && !stat.node_last;
            end
            rnvs_pkg::S_SELF_CAP:
            begin
                cmd.node_begin = 1'b1;
            end
            rnvs_pkg::S_EDGE_RD:
            begin
                cmd.edge_rd = stat.edge_more;
            end
            rnvs_pkg::S_EDGE_CHK:
            begin
                cmd.vrd_other = stat.edge_match;
                cmd.edge_skip = !stat.edge_match;
            end
            rnvs_pkg::S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
            end
            rnvs_pkg::S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
            end
            rnvs_pkg::S_ACC:
            begin
                cmd.acc_add = 1'b1;
            end
            rnvs_pkg::S_DIV_START:
            begin
                cmd.div_v = !stat.den_zero;
            end
            rnvs_pkg::S_VDIV:
            begin
                cmd.node_update = stat.div_done;
            end
            rnvs_pkg::S_NODE_ADV:
            begin
                cmd.node_next = !stat.node_last;
            end
            rnvs_pkg::S_SWEEP_END:
            begin
                cmd.sweep_start = stat.need_sweep;
                cmd.set_final   = !stat.need_sweep;
            end
            rnvs_pkg::S_OUT_SCAN:
            begin
                cmd.vrd_self  = stat.node_present;
                cmd.node_next = !stat.node_present;
            end
            rnvs_pkg::S_OUT_EMIT:
            begin
                cmd.emit_node = stat.out_free;
                cmd.node_next = stat.out_free && !stat.out_last;
            end
            default: cmd.load = 1'b0;
        endcase
    end

endmodule
